// ----- rtl/avr_pkg.sv -----
package avr_pkg;

   localparam int CoordWidth  = 32;
   localparam int AxisWidth   = 16;
   localparam int EntryWidth  = 18;
   localparam int CordicSteps = 20;
   localparam int OneQ16      = 65536;

   typedef logic signed [EntryWidth-1:0] entry_type;
   typedef entry_type [8:0] matrix_type;

   typedef struct packed {
      logic rebuild;
   } build_ctrl_type;

   typedef struct packed {
      logic ready;
      logic busy;
   } build_stat_type;

   // register indexes
   localparam logic [7:0] REG_AXIS_X = 8'd0;
   localparam logic [7:0] REG_AXIS_Y = 8'd1;
   localparam logic [7:0] REG_AXIS_Z = 8'd2;
   localparam logic [7:0] REG_ANGLE  = 8'd3;

   function automatic matrix_type identity_matrix();
      matrix_type m;
      for (int i = 0; i < 9; i++) begin
         m[i] = (i % 4 == 0) ? entry_type'(OneQ16) : entry_type'(0);
      end
      return m;
   endfunction

   // arctangent in units of 2^-32 turn
   function automatic logic [29:0] arctan_turn(input logic [4:0] i);
      logic [29:0] v;
      case (i)
         5'd0:  v = 30'd536870912;
         5'd1:  v = 30'd316933406;
         5'd2:  v = 30'd167458907;
         5'd3:  v = 30'd85004756;
         5'd4:  v = 30'd42667331;
         5'd5:  v = 30'd21354465;
         5'd6:  v = 30'd10679838;
         5'd7:  v = 30'd5340245;
         5'd8:  v = 30'd2670163;
         5'd9:  v = 30'd1335087;
         5'd10: v = 30'd667544;
         5'd11: v = 30'd333772;
         5'd12: v = 30'd166886;
         5'd13: v = 30'd83443;
         5'd14: v = 30'd41722;
         5'd15: v = 30'd20861;
         5'd16: v = 30'd10430;
         5'd17: v = 30'd5215;
         5'd18: v = 30'd2608;
         5'd19: v = 30'd1304;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

   function automatic logic [1:0] entry_row(input logic [3:0] e);
      logic [1:0] r;
      case (e)
         4'd0, 4'd1, 4'd2: r = 2'd0;
         4'd3, 4'd4, 4'd5: r = 2'd1;
         default:          r = 2'd2;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] entry_col(input logic [3:0] e);
      logic [1:0] c;
      case (e)
         4'd0, 4'd3, 4'd6: c = 2'd0;
         4'd1, 4'd4, 4'd7: c = 2'd1;
         default:          c = 2'd2;
      endcase
      return c;
   endfunction

   // axis component of the cross term; unused on the diagonal
   function automatic logic [1:0] entry_cross(input logic [3:0] e);
      logic [1:0] k;
      case (e)
         4'd5, 4'd7: k = 2'd0;
         4'd2, 4'd6: k = 2'd1;
         4'd1, 4'd3: k = 2'd2;
         default:    k = 2'd0;
      endcase
      return k;
   endfunction

   // cross term enters with a minus sign above the diagonal in cyclic order
   function automatic logic entry_minus(input logic [3:0] e);
      return (e == 4'd1) || (e == 4'd5) || (e == 4'd6);
   endfunction

endpackage

// ----- rtl/avr_ifs.sv -----
interface avr_req_if import avr_pkg::*; ();
   logic valid;
   logic ready;
   logic signed [CoordWidth-1:0] in_x;
   logic signed [CoordWidth-1:0] in_y;
   logic signed [CoordWidth-1:0] in_z;
   logic last_vector;
   modport source (output valid, in_x, in_y, in_z, last_vector, input ready);
   modport sink   (input valid, in_x, in_y, in_z, last_vector, output ready);
endinterface

interface avr_rsp_if import avr_pkg::*; ();
   logic valid;
   logic ready;
   logic signed [CoordWidth-1:0] out_x;
   logic signed [CoordWidth-1:0] out_y;
   logic signed [CoordWidth-1:0] out_z;
   logic out_last;
   logic saturated;
   modport source (output valid, out_x, out_y, out_z, out_last, saturated, input ready);
   modport sink   (input valid, out_x, out_y, out_z, out_last, saturated, output ready);
endinterface

interface avr_csr_if import avr_pkg::*; ();
   logic valid;
   logic ready;
   logic [7:0] index;
   logic [AxisWidth-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/axis_angle_vector_rotation.sv -----
// Axis-angle vector rotator. Each req_ transaction carries a Q16.16 vector and
// yields one rsp_ transaction with R*v, rounded and saturated to Q16.16, where
// R is the Rodrigues matrix for the axis and angle in the csr_ registers
// (0..2 axis x/y/z, any scale; 3 angle, 65536 = one turn). A zero axis gives
// the identity. After reset and after any write to a known register the matrix
// is rebuilt by a sequencer before the next vector is taken: norm, square root
// (one bit a cycle), normalizing division of each axis component, CORDIC and
// the nine entries, during which req_bus.ready stays low. Once built, the
// datapath takes one vector per cycle unless the output holds it back, through
// multiply, row sum, and round and saturate stages; each stage holds its item
// under backpressure and a free stage keeps accepting while a result waits at
// the output.
module axis_angle_vector_rotation import avr_pkg::*; (
   input logic  clock,
   input logic  reset,
   avr_req_if.sink   req_bus,
   avr_rsp_if.source rsp_bus,
   avr_csr_if.sink   csr_bus
);

   logic signed [AxisWidth-1:0] axis_ff [3];
   logic [AxisWidth-1:0]        angle_ff;
   logic                        csr_wr;
   logic                        known_reg;
   build_ctrl_type              ctrl;
   build_stat_type              stat;
   matrix_type                  matrix;

   // stage registers
   logic                 v1_ff, v2_ff, v3_ff;
   logic                 en1, en2, en3;
   logic signed [49:0]   prod_ff [9];
   logic signed [51:0]   acc_ff [3];
   logic                 last1_ff, last2_ff, last3_ff;
   logic signed [CoordWidth-1:0] res_ff [3];
   logic                 sat_ff;

   logic signed [CoordWidth-1:0] vin [3];
   logic signed [34:0]   rnd [3];
   logic signed [CoordWidth-1:0] res_in [3];
   logic [2:0]           clip;

   assign csr_bus.ready = 1'b1;
   assign csr_wr        = csr_bus.valid && csr_bus.ready;
   always_comb begin
      unique case (csr_bus.index)
         REG_AXIS_X, REG_AXIS_Y, REG_AXIS_Z, REG_ANGLE: known_reg = 1'b1;
         default: known_reg = 1'b0;
      endcase
   end
   assign ctrl.rebuild = csr_wr && known_reg;

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff[0] <= '0;
         axis_ff[1] <= '0;
         axis_ff[2] <= 16'sd16384;
         angle_ff   <= '0;
      end else if (csr_wr) begin
         unique case (csr_bus.index)
            REG_AXIS_X: axis_ff[0] <= csr_bus.data;
            REG_AXIS_Y: axis_ff[1] <= csr_bus.data;
            REG_AXIS_Z: axis_ff[2] <= csr_bus.data;
            REG_ANGLE:  angle_ff   <= csr_bus.data;
            default: ;
         endcase
      end
   end

   avr_matrix_build u_build (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .axis   (axis_ff),
      .angle  (angle_ff),
      .stat   (stat),
      .matrix (matrix)
   );

   // a stage advances when it is empty or the next one advances
   assign en3 = !v3_ff || rsp_bus.ready;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_bus.ready = en1 && stat.ready && !stat.busy;

   assign vin[0] = req_bus.in_x;
   assign vin[1] = req_bus.in_y;
   assign vin[2] = req_bus.in_z;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         rnd[r]    = 35'((acc_ff[r] + 52'sd32768) >>> 16);
         clip[r]   = !((rnd[r][34:31] == 4'b0000) || (rnd[r][34:31] == 4'b1111));
         res_in[r] = !clip[r] ? rnd[r][31:0] :
                     rnd[r][34] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_bus.valid && req_bus.ready;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
      // multiply: one product per matrix entry
      if (en1) begin
         for (int i = 0; i < 9; i++) begin
            prod_ff[i] <= $signed(matrix[i]) * vin[i % 3];
         end
         last1_ff <= req_bus.last_vector;
      end
      // sum each row
      if (en2) begin
         for (int r = 0; r < 3; r++) begin
            acc_ff[r] <= 52'(prod_ff[3*r]) + 52'(prod_ff[3*r+1]) + 52'(prod_ff[3*r+2]);
         end
         last2_ff <= last1_ff;
      end
      // round, saturate and hold for the sink
      if (en3) begin
         res_ff   <= res_in;
         sat_ff   <= |clip;
         last3_ff <= last2_ff;
      end
   end

   assign rsp_bus.valid     = v3_ff;
   assign rsp_bus.out_x     = res_ff[0];
   assign rsp_bus.out_y     = res_ff[1];
   assign rsp_bus.out_z     = res_ff[2];
   assign rsp_bus.out_last  = last3_ff;
   assign rsp_bus.saturated = sat_ff;

endmodule

// ----- rtl/avr_matrix_build.sv -----
module avr_matrix_build import avr_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  build_ctrl_type              ctrl,
   input  logic signed [AxisWidth-1:0] axis [3],
   input  logic [AxisWidth-1:0]        angle,
   output build_stat_type              stat,
   output matrix_type                  matrix
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_NORM   = 3'd1;
   localparam logic [2:0] S_SQRT   = 3'd2;
   localparam logic [2:0] S_DIV    = 3'd3;
   localparam logic [2:0] S_CORDIC = 3'd4;
   localparam logic [2:0] S_MAT    = 3'd5;

   logic [2:0]  state_ff, state_in;
   logic        ready_ff, ready_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [1:0]  sel_ff, sel_in;
   logic [1:0]  phase_ff, phase_in;
   logic [31:0] n2_ff, n2_in;
   logic [63:0] rad_ff, rad_in;
   logic [34:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [48:0] num_ff, num_in;
   logic [48:0] dv_ff, dv_in;
   logic [17:0] q_ff, q_in;
   entry_type   u_ff [3];
   entry_type   u_in [3];
   logic signed [32:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   entry_type   c_ff, c_in, s_ff, s_in;
   logic signed [35:0] p1_ff, p1_in, p2_ff, p2_in;
   logic signed [54:0] p3_ff, p3_in;
   matrix_type  mat_ff, mat_in;

   logic signed [31:0] sq;
   logic [16:0]        mag;
   logic [34:0]        rem_sh;
   logic [33:0]        trial;
   logic signed [32:0] cs, sn, cr, sr;
   logic [3:0]         ent;
   logic signed [18:0] cp;
   logic signed [22:0] t_main;
   logic signed [19:0] t_cross;
   logic signed [23:0] e_sum;

   assign stat.ready = ready_ff;
   assign stat.busy  = state_ff != S_IDLE;
   assign matrix     = mat_ff;
   assign ent        = cnt_ff[3:0];

   always_comb begin
      state_in = state_ff;
      ready_in = ready_ff;
      cnt_in   = cnt_ff;
      sel_in   = sel_ff;
      phase_in = phase_ff;
      n2_in    = n2_ff;
      rad_in   = rad_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      num_in   = num_ff;
      dv_in    = dv_ff;
      q_in     = q_ff;
      u_in     = u_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      c_in     = c_ff;
      s_in     = s_ff;
      p1_in    = p1_ff;
      p2_in    = p2_ff;
      p3_in    = p3_ff;
      mat_in   = mat_ff;

      sq      = axis[sel_ff] * axis[sel_ff];
      mag     = axis[sel_ff][AxisWidth-1] ? 17'(-{axis[sel_ff][AxisWidth-1], axis[sel_ff]})
                                          : 17'(axis[sel_ff]);
      rem_sh  = {rem_ff[32:0], rad_ff[63:62]};
      trial   = {root_ff, 2'b01};
      cs      = '0;
      sn      = '0;
      cr      = '0;
      sr      = '0;
      cp      = 19'sd65536 - 19'(c_ff);
      t_main  = 23'((p3_ff + 55'sd2147483648) >>> 32);
      t_cross = 20'((p2_ff + 36'sd32768) >>> 16);
      e_sum   = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (!ready_ff) begin
               state_in = S_NORM;
               sel_in   = 2'd0;
               n2_in    = '0;
            end
         end
         S_NORM: begin
            n2_in = n2_ff + 32'(sq);
            if (sel_ff == 2'd2) begin
               if (n2_in == 32'd0) begin
                  mat_in   = identity_matrix();
                  ready_in = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  rad_in   = {n2_in, 32'd0};
                  rem_in   = '0;
                  root_in  = '0;
                  cnt_in   = 5'd0;
                  state_in = S_SQRT;
               end
            end else begin
               sel_in = sel_ff + 2'd1;
            end
         end
         S_SQRT: begin
            // one result bit a cycle
            rad_in = {rad_ff[61:0], 2'b00};
            if (rem_sh >= 35'(trial)) begin
               rem_in  = rem_sh - 35'(trial);
               root_in = {root_ff[30:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_ff[30:0], 1'b0};
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               sel_in   = 2'd0;
               state_in = S_DIV;
               phase_in = 2'd0;
            end
         end
         S_DIV: begin
            if (phase_ff == 2'd0) begin
               num_in   = {mag, 32'd0} + 49'(root_ff >> 1);
               dv_in    = {root_ff, 17'd0};
               q_in     = '0;
               cnt_in   = 5'd0;
               phase_in = 2'd1;
            end else if (phase_ff == 2'd1) begin
               if (num_ff >= dv_ff) begin
                  num_in = num_ff - dv_ff;
                  q_in   = {q_ff[16:0], 1'b1};
               end else begin
                  q_in   = {q_ff[16:0], 1'b0};
               end
               dv_in  = dv_ff >> 1;
               cnt_in = cnt_ff + 5'd1;
               if (cnt_ff == 5'd17) phase_in = 2'd2;
            end else begin
               // clamp to one, then apply the sign
               if (q_ff > 18'd65536) begin
                  u_in[sel_ff] = axis[sel_ff][AxisWidth-1] ? -entry_type'(OneQ16)
                                                           : entry_type'(OneQ16);
               end else begin
                  u_in[sel_ff] = axis[sel_ff][AxisWidth-1] ? -entry_type'(q_ff)
                                                           : entry_type'(q_ff);
               end
               phase_in = 2'd0;
               if (sel_ff == 2'd2) begin
                  x_in     = 33'sd652032874;
                  y_in     = '0;
                  z_in     = 33'({2'b00, angle[13:0], 16'd0});
                  cnt_in   = 5'd0;
                  state_in = S_CORDIC;
               end else begin
                  sel_in = sel_ff + 2'd1;
               end
            end
         end
         S_CORDIC: begin
            if (!z_ff[32]) begin
               x_in = x_ff - (y_ff >>> cnt_ff);
               y_in = y_ff + (x_ff >>> cnt_ff);
               z_in = z_ff - 33'(arctan_turn(cnt_ff));
            end else begin
               x_in = x_ff + (y_ff >>> cnt_ff);
               y_in = y_ff - (x_ff >>> cnt_ff);
               z_in = z_ff + 33'(arctan_turn(cnt_ff));
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(CordicSteps - 1)) begin
               case (angle[15:14])
                  2'd0:    begin cs = x_in;  sn = y_in;  end
                  2'd1:    begin cs = -y_in; sn = x_in;  end
                  2'd2:    begin cs = -x_in; sn = -y_in; end
                  default: begin cs = y_in;  sn = -x_in; end
               endcase
               cr = (cs + 33'sd8192) >>> 14;
               sr = (sn + 33'sd8192) >>> 14;
               c_in = (cr > 33'sd65536) ? entry_type'(OneQ16) :
                      (cr < -33'sd65536) ? -entry_type'(OneQ16) : entry_type'(cr);
               s_in = (sr > 33'sd65536) ? entry_type'(OneQ16) :
                      (sr < -33'sd65536) ? -entry_type'(OneQ16) : entry_type'(sr);
               cnt_in   = 5'd0;
               phase_in = 2'd0;
               state_in = S_MAT;
            end
         end
         S_MAT: begin
            if (phase_ff == 2'd0) begin
               p1_in    = u_ff[entry_row(ent)] * u_ff[entry_col(ent)];
               p2_in    = u_ff[entry_cross(ent)] * s_ff;
               phase_in = 2'd1;
            end else if (phase_ff == 2'd1) begin
               p3_in    = p1_ff * cp;
               phase_in = 2'd2;
            end else begin
               if (entry_row(ent) == entry_col(ent)) begin
                  e_sum = 24'(t_main) + 24'(c_ff);
               end else if (entry_minus(ent)) begin
                  e_sum = 24'(t_main) - 24'(t_cross);
               end else begin
                  e_sum = 24'(t_main) + 24'(t_cross);
               end
               mat_in[ent] = (e_sum > 24'sd131071) ? entry_type'(131071) :
                             (e_sum < -24'sd131072) ? entry_type'(-131072) :
                             entry_type'(e_sum);
               phase_in = 2'd0;
               cnt_in   = cnt_ff + 5'd1;
               if (ent == 4'd8) begin
                  ready_in = 1'b1;
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase

      // a write to a known register drops the matrix and restarts the build
      if (ctrl.rebuild) begin
         ready_in = 1'b0;
         state_in = S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b0;
         mat_ff   <= identity_matrix();
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
         mat_ff   <= mat_in;
      end
      cnt_ff   <= cnt_in;
      sel_ff   <= sel_in;
      phase_ff <= phase_in;
      n2_ff    <= n2_in;
      rad_ff   <= rad_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      num_ff   <= num_in;
      dv_ff    <= dv_in;
      q_ff     <= q_in;
      u_ff     <= u_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      z_ff     <= z_in;
      c_ff     <= c_in;
      s_ff     <= s_in;
      p1_ff    <= p1_in;
      p2_ff    <= p2_in;
      p3_ff    <= p3_in;
   end

endmodule

// ----- verif/axis_angle_vector_rotation_tb.sv -----
`timescale 1ns / 100ps

module axis_angle_vector_rotation_tb;
   import avr_pkg::*;

   localparam int          CycleLimit  = 400000;
   localparam int          HoldCycles  = 300;
   localparam int          IdlePercent = 38;
   localparam int          RandPhases  = 7;
   localparam int          PhaseItems  = 130;
   // index outside the register map; the block must drop such writes
   localparam logic [7:0]  REG_NONE    = 8'd7;
   localparam longint      EntryHi     = 131071;
   localparam longint      EntryLo     = -131072;
   localparam longint      CoordHi     = 64'sd2147483647;
   localparam longint      CoordLo     = -64'sd2147483648;

   localparam longint ArcTurn [CordicSteps] = '{
      536870912, 316933406, 167458907, 85004756, 42667331,
      21354465, 10679838, 5340245, 2670163, 1335087,
      667544, 333772, 166886, 83443, 41722,
      20861, 10430, 5215, 2608, 1304
   };

   typedef struct {
      logic signed [CoordWidth-1:0] x, y, z;
      logic                         last;
   } vector_type;

   typedef struct {
      logic signed [CoordWidth-1:0] x, y, z;
      logic                         last;
      logic                         sat;
   } rotated_type;

   typedef enum {KEEP_SETUP, ZERO_AXIS, SKEW_AXIS} setup_type;

   typedef struct {
      setup_type   setup;
      vector_type  v;
      bit          typed;   // expected result written in the row
      rotated_type r;
   } stim_row_type;

   logic clock;
   logic reset;

   avr_req_if req_bus ();
   avr_rsp_if rsp_bus ();
   avr_csr_if csr_bus ();

   axis_angle_vector_rotation u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // predictor state: register copies and the derived rotation matrix
   logic [AxisWidth-1:0] axis_reg [3];
   logic [AxisWidth-1:0] angle_reg;
   longint               rot_matrix [9];
   bit                   matrix_valid;

   rotated_type pending_rotations [$];
   int       mismatch_count;
   int       cycle_count;
   bit       calm;            // no idling on either side
   bit       hold_request;    // ask the receiver for a long hold-off
   int       hold_left;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Reference arithmetic
   // ---------------------------------------------------------------------
   function automatic longint clip(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // round to nearest, ties toward plus infinity
   function automatic longint round_drop(input longint v, input int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned n);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // CORDIC sine/cosine in Q2.16 from a 16-bit fraction of a turn
   task automatic angle_sin_cos(input logic [15:0] ang, output longint sn, output longint cs);
      logic [31:0] t;
      longint      x, y, z, dx, dy, c, s;
      t = {ang, 16'd0};
      z = longint'(t[29:0]);
      x = 652032874;
      y = 0;
      for (int i = 0; i < CordicSteps; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= ArcTurn[i];
         end else begin
            x += dx; y -= dy; z += ArcTurn[i];
         end
      end
      case (t[31:30])
         2'd0:    begin c = x;  s = y;  end
         2'd1:    begin c = -y; s = x;  end
         2'd2:    begin c = -x; s = -y; end
         default: begin c = y;  s = -x; end
      endcase
      cs = clip(round_drop(c, 14), -OneQ16, OneQ16);
      sn = clip(round_drop(s, 14), -OneQ16, OneQ16);
   endtask

   task automatic rebuild_rotation();
      longint          a [3];
      longint          u [3];
      longint          s, c, cp, e, q;
      longint unsigned n2, root, mag;
      int              k;
      n2 = 0;
      for (int i = 0; i < 3; i++) begin
         a[i] = longint'($signed(axis_reg[i]));
         n2 += longint'(a[i] * a[i]);
      end
      if (n2 == 0) begin
         // zero axis: identity instead of a divide by zero
         for (int i = 0; i < 9; i++) rot_matrix[i] = (i % 4 == 0) ? OneQ16 : 0;
         return;
      end
      root = int_sqrt(n2 << 32);
      for (int i = 0; i < 3; i++) begin
         mag  = longint'((a[i] < 0) ? -a[i] : a[i]) << 32;
         q    = longint'((mag + root / 2) / root);
         u[i] = clip((a[i] < 0) ? -q : q, -OneQ16, OneQ16);
      end
      angle_sin_cos(angle_reg, s, c);
      cp = OneQ16 - c;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            e = round_drop(u[i] * u[j] * cp, 32);
            k = 3 - i - j;
            if (i == j) e += c;
            else if ((j - i + 3) % 3 == 1) e -= round_drop(u[k] * s, 16);
            else e += round_drop(u[k] * s, 16);
            rot_matrix[i*3 + j] = clip(e, EntryLo, EntryHi);
         end
      end
   endtask

   task automatic rotate_vector(input vector_type v, output rotated_type r);
      longint vin [3];
      longint acc, rnd, cl;
      logic signed [CoordWidth-1:0] o [3];
      if (!matrix_valid) begin
         rebuild_rotation();
         matrix_valid = 1'b1;
      end
      vin[0] = v.x; vin[1] = v.y; vin[2] = v.z;
      r.sat = 1'b0;
      for (int i = 0; i < 3; i++) begin
         acc = rot_matrix[i*3] * vin[0] + rot_matrix[i*3+1] * vin[1]
             + rot_matrix[i*3+2] * vin[2];
         rnd = round_drop(acc, 16);
         cl  = clip(rnd, CoordLo, CoordHi);
         if (cl != rnd) r.sat = 1'b1;
         o[i] = cl[CoordWidth-1:0];
      end
      r.x = o[0]; r.y = o[1]; r.z = o[2];
      r.last = v.last;
   endtask

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------
   task automatic write_register(input logic [7:0] idx, input logic [15:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_AXIS_X: axis_reg[0] = data;
         REG_AXIS_Y: axis_reg[1] = data;
         REG_AXIS_Z: axis_reg[2] = data;
         REG_ANGLE:  angle_reg   = data;
         default:    return;   // unknown index keeps the matrix
      endcase
      matrix_valid = 1'b0;
   endtask

   task automatic write_setup(input logic [15:0] ax, input logic [15:0] ay,
                              input logic [15:0] az, input logic [15:0] ang);
      write_register(REG_AXIS_X, ax);
      write_register(REG_AXIS_Y, ay);
      write_register(REG_AXIS_Z, az);
      write_register(REG_ANGLE, ang);
   endtask

   // offer one vector, hold it until taken, then queue what it must produce
   task automatic send_vector(input vector_type v, input bit typed, input rotated_type given);
      rotated_type r;
      req_bus.valid       <= 1'b1;
      req_bus.in_x        <= v.x;
      req_bus.in_y        <= v.y;
      req_bus.in_z        <= v.z;
      req_bus.last_vector <= v.last;
      do @(posedge clock); while (!req_bus.ready);
      rotate_vector(v, r);
      pending_rotations.push_back(typed ? given : r);
      if (!calm && $urandom_range(0, 99) < IdlePercent) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
   endtask

   // drop valid and wait until every rotation has come back
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_rotations.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   function automatic logic [31:0] random_coord();
      logic [31:0] c;
      case ($urandom_range(0, 5))
         0:       c = $urandom;
         1:       c = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
         2:       c = 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
         default: c = 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
      endcase
      return c;
   endfunction

   function automatic logic [15:0] random_axis();
      case ($urandom_range(0, 4))
         0:       return 16'h7fff;
         1:       return 16'h8000;
         2:       return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] random_angle();
      case ($urandom_range(0, 5))
         0:       return 16'h0000;
         1:       return 16'hffff;
         2:       return 16'h4000;
         3:       return 16'h8000;
         default: return 16'($urandom);
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Receiver: random backpressure, long hold-off on request, and check
   // ---------------------------------------------------------------------
   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t rotation mismatch on %s: got %h, want %h", $realtime, field, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      rotated_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_rotations.size() == 0) begin
               $display("%0t rotation with nothing pending", $realtime);
               mismatch_count++;
            end else begin
               want = pending_rotations.pop_front();
               if (rsp_bus.out_x !== want.x) report_mismatch("out_x", rsp_bus.out_x, want.x);
               if (rsp_bus.out_y !== want.y) report_mismatch("out_y", rsp_bus.out_y, want.y);
               if (rsp_bus.out_z !== want.z) report_mismatch("out_z", rsp_bus.out_z, want.z);
               if (rsp_bus.out_last !== want.last)
                  report_mismatch("out_last", rsp_bus.out_last, want.last);
               if (rsp_bus.saturated !== want.sat)
                  report_mismatch("saturated", rsp_bus.saturated, want.sat);
            end
         end
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HoldCycles;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= calm || ($urandom_range(0, 99) >= IdlePercent);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   function automatic stim_row_type row(input setup_type s, input logic [31:0] x,
                                        input logic [31:0] y, input logic [31:0] z,
                                        input logic l, input bit typed);
      stim_row_type t;
      t.setup = s;
      t.v.x = x; t.v.y = y; t.v.z = z; t.v.last = l;
      t.typed = typed;
      // typed rows only appear under the zero axis, where R is the identity
      t.r.x = x; t.r.y = y; t.r.z = z; t.r.last = l; t.r.sat = 1'b0;
      return t;
   endfunction

   initial begin
      stim_row_type directed [$];
      vector_type   v;
      rotated_type  unused;
      int           set_left;

      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.in_x        <= '0;
      req_bus.in_y        <= '0;
      req_bus.in_z        <= '0;
      req_bus.last_vector <= 1'b0;
      csr_bus.valid       <= 1'b0;
      csr_bus.index       <= REG_AXIS_X;
      csr_bus.data        <= '0;
      axis_reg[0] = 16'd0;
      axis_reg[1] = 16'd0;
      axis_reg[2] = 16'd16384;
      angle_reg   = 16'd0;
      for (int i = 0; i < 9; i++) rot_matrix[i] = (i % 4 == 0) ? OneQ16 : 0;
      matrix_valid   = 1'b0;
      mismatch_count = 0;
      cycle_count    = 0;
      calm           = 1'b0;
      hold_request   = 1'b0;
      hold_left      = 0;
      unused = '{default: '0};

      // reset state (axis along z, zero angle), then zero axis, then a skew axis
      directed = '{
         row(KEEP_SETUP, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b0, 1'b0),
         row(KEEP_SETUP, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b1, 1'b0),
         row(KEEP_SETUP, 32'hffff_ffff, 32'h0000_0001, 32'h0000_8000, 1'b1, 1'b0),
         row(ZERO_AXIS,  32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1),
         row(ZERO_AXIS,  32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0, 1'b1),
         row(ZERO_AXIS,  32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b1),
         row(ZERO_AXIS,  32'h5555_aaaa, 32'haaaa_5555, 32'hffff_0000, 1'b1, 1'b1),
         row(ZERO_AXIS,  32'h0000_0001, 32'hffff_ffff, 32'h0001_0000, 1'b0, 1'b1),
         row(SKEW_AXIS,  32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0, 1'b0),
         row(SKEW_AXIS,  32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0),
         row(SKEW_AXIS,  32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b0),
         row(SKEW_AXIS,  32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0),
         row(SKEW_AXIS,  32'h0000_0000, 32'h0001_0000, 32'hffff_0000, 1'b1, 1'b0)
      };

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // walk the table; apply its setup the first time it changes
      for (int i = 0; i < directed.size(); i++) begin
         if (i > 0 && directed[i].setup != directed[i-1].setup) begin
            drain();
            if (directed[i].setup == ZERO_AXIS) begin
               write_setup(16'h0000, 16'h0000, 16'h0000, 16'h4000);
               write_register(REG_NONE, 16'h1234);   // must be ignored
            end else begin
               write_setup(16'h7fff, 16'h8000, 16'h0001, 16'h4000);
            end
         end
         send_vector(directed[i].v, directed[i].typed, directed[i].r);
      end

      // random phases: new setup per phase, vectors in sets closed by last_vector
      for (int p = 0; p < RandPhases; p++) begin
         drain();
         write_setup(random_axis(), random_axis(), random_axis(), random_angle());
         if (p == 1) write_setup(16'h8000, 16'h8000, 16'h8000, 16'hffff);
         if ($urandom_range(0, 3) == 0) write_register(REG_NONE, 16'($urandom));
         calm = (p == 4);
         if (p == 2) hold_request = 1'b1;   // receiver stalls, sender keeps offering
         set_left = $urandom_range(1, 8);
         for (int n = 0; n < PhaseItems; n++) begin
            if (p == 3 && n == PhaseItems / 2) drain();   // sender pauses until empty
            v.x = random_coord();
            v.y = random_coord();
            v.z = random_coord();
            set_left--;
            // mostly well-formed sets; now and then a stray marker
            v.last = (set_left == 0) || ($urandom_range(0, 19) == 0);
            if (set_left == 0) set_left = $urandom_range(1, 8);
            send_vector(v, 1'b0, unused);
         end
      end

      calm = 1'b0;
      drain();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/avr_pkg.sv
rtl/avr_ifs.sv
rtl/avr_matrix_build.sv
rtl/axis_angle_vector_rotation.sv
verif/axis_angle_vector_rotation_tb.sv
